[hdl/liv_pkg.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// liv_pkg
// Shared types and constants for the lowest-index graph visit order block.
// ----------------------------------------------------------------------------
package liv_pkg;

   localparam int CMD_W    = 3;
   localparam int VTX_W    = 6;
   localparam int MAX_ROWS = 64;

   typedef enum logic [CMD_W-1:0] {
      CMD_ADD_EDGE = 3'd0,
      CMD_MARK_BAD = 3'd1,
      CMD_FORBID   = 3'd2,
      CMD_RUN      = 3'd3,
      CMD_CLEAR    = 3'd4
   } liv_cmd_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_LD_RD_A,
      ST_LD_WR_A,
      ST_LD_WR_B,
      ST_SCAN_RD,
      ST_SCAN_CHK,
      ST_WALK_RD,
      ST_WALK_UPD,
      ST_EMIT
   } liv_state_type;

   typedef struct packed {
      logic wr_en;
      logic clr;
   } liv_mem_ctl_type;

endpackage
`default_nettype wire

[hdl/liv_if.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// liv_if
// Valid/ready channels for commands and visit results.
// ----------------------------------------------------------------------------
interface liv_req_if;
   logic                       valid;
   logic                       ready;
   logic [liv_pkg::CMD_W-1:0]  cmd;
   logic [liv_pkg::VTX_W-1:0]  vertex_a;
   logic [liv_pkg::VTX_W-1:0]  vertex_b;

   modport source (output valid, cmd, vertex_a, vertex_b, input ready);
   modport sink   (input valid, cmd, vertex_a, vertex_b, output ready);
endinterface

interface liv_rsp_if;
   logic                       valid;
   logic                       ready;
   logic [liv_pkg::VTX_W-1:0]  visited_vertex;
   logic                       last;
   logic                       empty_graph;

   modport source (output valid, visited_vertex, last, empty_graph, input ready);
   modport sink   (input valid, visited_vertex, last, empty_graph, output ready);
endinterface
`default_nettype wire

[hdl/liv_mem.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// liv_mem
// Square bit matrix, one row write and one registered row read per cycle,
// with per-row valid bits so a clear takes effect at once.
// ----------------------------------------------------------------------------
module liv_mem #(
   parameter int DEPTH  = 64,
   parameter int ADDR_W = 6
) (
   input  wire logic                     clock,
   input  wire logic                     reset,
   input  wire liv_pkg::liv_mem_ctl_type ctl,
   input  wire logic [ADDR_W-1:0]        waddr,
   input  wire logic [DEPTH-1:0]         wdata,
   input  wire logic [ADDR_W-1:0]        raddr,
   output      logic [DEPTH-1:0]         rdata
);

   logic [DEPTH-1:0] mem_ff [DEPTH];
   logic [DEPTH-1:0] valid_ff;
   logic [DEPTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else if (ctl.clr) begin
         valid_ff <= '0;
      end else if (ctl.wr_en) begin
         valid_ff[waddr] <= 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (ctl.wr_en) begin
         mem_ff[waddr] <= wdata;
      end
      rdata_ff <= valid_ff[raddr] ? mem_ff[raddr] : '0;
   end

   assign rdata = rdata_ff;

endmodule
`default_nettype wire

[hdl/liv_row_unit.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// liv_row_unit
// Shared row evaluator: masks one adjacency row into its effective edges,
// merges it into the frontier and picks the lowest frontier vertex.
// ----------------------------------------------------------------------------
module liv_row_unit #(
   parameter int NUM_ROWS = 64,
   parameter int ROW_W    = 6
) (
   input  wire logic [NUM_ROWS-1:0] adj_row,
   input  wire logic [NUM_ROWS-1:0] forb_row,
   input  wire logic [NUM_ROWS-1:0] bad,
   input  wire logic [ROW_W-1:0]    idx,
   input  wire logic [NUM_ROWS-1:0] visited,
   input  wire logic [NUM_ROWS-1:0] frontier,
   output      logic                eff_any,
   output      logic [NUM_ROWS-1:0] visited_upd,
   output      logic [NUM_ROWS-1:0] frontier_upd,
   output      logic [ROW_W-1:0]    pick_idx,
   output      logic [NUM_ROWS-1:0] frontier_pop
);

   logic [NUM_ROWS-1:0] eff_row;
   logic [NUM_ROWS-1:0] iso;

   always_comb begin
      eff_row      = bad[idx] ? '0 : (adj_row & ~bad & ~forb_row);
      eff_any      = |eff_row;
      visited_upd  = visited | (NUM_ROWS'(1) << idx);
      frontier_upd = (frontier | eff_row) & ~visited_upd;
   end

   // lowest set bit of the frontier
   always_comb begin
      iso          = frontier & (~frontier + NUM_ROWS'(1));
      frontier_pop = frontier & (frontier - NUM_ROWS'(1));
      pick_idx     = '0;
      for (int k = 0; k < NUM_ROWS; k++) begin
         if (iso[k]) begin
            pick_idx = pick_idx | ROW_W'(k);
         end
      end
   end

endmodule
`default_nettype wire

[hdl/lowest_index_graph_visit_order.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// lowest_index_graph_visit_order
// Loads edges, bad vertices and forbidden pairs into bit matrices and walks
// the effective graph, always visiting the lowest-numbered frontier vertex.
//
// Usage:
//  req_bus carries one command per transaction: add edge, mark bad vertex,
//  forbid pair, run walk or clear all. rsp_bus carries one transaction per
//  visited vertex of a run, with last on the final one; a run over a graph
//  with no effective edge returns a single transaction flagged empty_graph.
//  Sequencing: mark bad, clear and unused codes complete in the idle state;
//  add edge and forbid pair pass through LD_RD_A, LD_WR_A and LD_WR_B
//  (read-modify-write of both matrix rows through the single read port). A
//  run scans rows (SCAN_RD, SCAN_CHK) until the start vertex is found, then
//  per visited vertex does the row read (WALK_RD), the frontier update and
//  result register (WALK_UPD) and the result output (EMIT), held by stalls.
//  req_bus.ready is low while a command is in progress; a stalled result
//  holds the walk in place with its transaction unchanged.
//  Reset empties all matrices at once through row valid bits and clears
//  the bad set; the block is ready in the first cycle after reset.
// ----------------------------------------------------------------------------
module lowest_index_graph_visit_order #(
   parameter int VERTICES = 64
) (
   input  wire logic  clock,
   input  wire logic  reset,
   liv_req_if.sink    req_bus,
   liv_rsp_if.source  rsp_bus
);

   localparam int NUM_ROWS = (VERTICES < liv_pkg::MAX_ROWS) ? VERTICES : liv_pkg::MAX_ROWS;
   localparam int ROW_W    = $clog2(NUM_ROWS);
   localparam int VTX_W    = liv_pkg::VTX_W;
   localparam logic [VTX_W:0]   ROW_LIMIT = (VTX_W+1)'(NUM_ROWS);
   localparam logic [ROW_W-1:0] LAST_ROW  = ROW_W'(NUM_ROWS - 1);

   liv_pkg::liv_state_type   state_ff;
   liv_pkg::liv_state_type   state_in;
   liv_pkg::liv_cmd_type     cmd_in;

   logic [NUM_ROWS-1:0] bad_ff;
   logic [ROW_W-1:0]    a_ff;
   logic [ROW_W-1:0]    b_ff;
   logic                is_forb_ff;
   logic [ROW_W-1:0]    idx_ff;
   logic [NUM_ROWS-1:0] visited_ff;
   logic [NUM_ROWS-1:0] frontier_ff;
   logic [VTX_W-1:0]    rsp_vertex_ff;
   logic                rsp_last_ff;
   logic                rsp_empty_ff;

   logic                a_ok;
   logic                b_ok;
   logic                req_go;
   logic                rsp_go;

   liv_pkg::liv_mem_ctl_type adj_ctl;
   liv_pkg::liv_mem_ctl_type forb_ctl;
   logic [ROW_W-1:0]    rd_addr;
   logic [ROW_W-1:0]    wr_addr;
   logic [NUM_ROWS-1:0] wr_row;
   logic [NUM_ROWS-1:0] rd_row;
   logic [NUM_ROWS-1:0] adj_rdata;
   logic [NUM_ROWS-1:0] forb_rdata;

   logic                eff_any;
   logic [NUM_ROWS-1:0] visited_upd;
   logic [NUM_ROWS-1:0] frontier_upd;
   logic [ROW_W-1:0]    pick_idx;
   logic [NUM_ROWS-1:0] frontier_pop;

   assign cmd_in = liv_pkg::liv_cmd_type'(req_bus.cmd);
   assign a_ok   = {1'b0, req_bus.vertex_a} < ROW_LIMIT;
   assign b_ok   = {1'b0, req_bus.vertex_b} < ROW_LIMIT;
   assign req_go = req_bus.valid && req_bus.ready;
   assign rsp_go = rsp_bus.valid && rsp_bus.ready;
   assign rd_row = is_forb_ff ? forb_rdata : adj_rdata;

   liv_mem #(
      .DEPTH  (NUM_ROWS),
      .ADDR_W (ROW_W)
   ) u_adj_mem (
      .clock (clock),
      .reset (reset),
      .ctl   (adj_ctl),
      .waddr (wr_addr),
      .wdata (wr_row),
      .raddr (rd_addr),
      .rdata (adj_rdata)
   );

   liv_mem #(
      .DEPTH  (NUM_ROWS),
      .ADDR_W (ROW_W)
   ) u_forb_mem (
      .clock (clock),
      .reset (reset),
      .ctl   (forb_ctl),
      .waddr (wr_addr),
      .wdata (wr_row),
      .raddr (rd_addr),
      .rdata (forb_rdata)
   );

   liv_row_unit #(
      .NUM_ROWS (NUM_ROWS),
      .ROW_W    (ROW_W)
   ) u_row_unit (
      .adj_row      (adj_rdata),
      .forb_row     (forb_rdata),
      .bad          (bad_ff),
      .idx          (idx_ff),
      .visited      (visited_ff),
      .frontier     (frontier_ff),
      .eff_any      (eff_any),
      .visited_upd  (visited_upd),
      .frontier_upd (frontier_upd),
      .pick_idx     (pick_idx),
      .frontier_pop (frontier_pop)
   );

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         liv_pkg::ST_IDLE: begin
            if (req_bus.valid) begin
               unique case (cmd_in) inside
                  liv_pkg::CMD_ADD_EDGE, liv_pkg::CMD_FORBID: begin
                     if (a_ok && b_ok) state_in = liv_pkg::ST_LD_RD_A;
                  end
                  liv_pkg::CMD_RUN: state_in = liv_pkg::ST_SCAN_RD;
                  default: state_in = liv_pkg::ST_IDLE;
               endcase
            end
         end
         liv_pkg::ST_LD_RD_A:  state_in = liv_pkg::ST_LD_WR_A;
         liv_pkg::ST_LD_WR_A:  state_in = liv_pkg::ST_LD_WR_B;
         liv_pkg::ST_LD_WR_B:  state_in = liv_pkg::ST_IDLE;
         liv_pkg::ST_SCAN_RD:  state_in = liv_pkg::ST_SCAN_CHK;
         liv_pkg::ST_SCAN_CHK: begin
            if (eff_any) begin
               state_in = liv_pkg::ST_WALK_RD;
            end else if (idx_ff == LAST_ROW) begin
               state_in = liv_pkg::ST_EMIT;
            end else begin
               state_in = liv_pkg::ST_SCAN_RD;
            end
         end
         liv_pkg::ST_WALK_RD:  state_in = liv_pkg::ST_WALK_UPD;
         liv_pkg::ST_WALK_UPD: state_in = liv_pkg::ST_EMIT;
         liv_pkg::ST_EMIT: begin
            if (rsp_bus.ready) begin
               state_in = rsp_last_ff ? liv_pkg::ST_IDLE : liv_pkg::ST_WALK_RD;
            end
         end
         default: state_in = liv_pkg::ST_IDLE;
      endcase
   end

   // outputs
   always_comb begin
      req_bus.ready = 1'b0;
      rsp_bus.valid = 1'b0;
      rd_addr       = idx_ff;
      wr_addr       = a_ff;
      wr_row        = rd_row | (NUM_ROWS'(1) << b_ff);
      adj_ctl       = '0;
      forb_ctl      = '0;
      unique case (state_ff)
         liv_pkg::ST_IDLE: begin
            req_bus.ready = 1'b1;
            if (req_bus.valid && cmd_in == liv_pkg::CMD_CLEAR) begin
               adj_ctl.clr  = 1'b1;
               forb_ctl.clr = 1'b1;
            end
         end
         liv_pkg::ST_LD_RD_A: begin
            rd_addr = a_ff;
         end
         liv_pkg::ST_LD_WR_A: begin
            rd_addr        = b_ff;
            adj_ctl.wr_en  = !is_forb_ff;
            forb_ctl.wr_en = is_forb_ff;
         end
         liv_pkg::ST_LD_WR_B: begin
            wr_addr        = b_ff;
            wr_row         = rd_row | (NUM_ROWS'(1) << a_ff);
            adj_ctl.wr_en  = !is_forb_ff;
            forb_ctl.wr_en = is_forb_ff;
         end
         liv_pkg::ST_SCAN_RD, liv_pkg::ST_SCAN_CHK,
         liv_pkg::ST_WALK_RD, liv_pkg::ST_WALK_UPD: begin
            rd_addr = idx_ff;
         end
         liv_pkg::ST_EMIT: begin
            rsp_bus.valid = 1'b1;
         end
         default: rsp_bus.valid = 1'b0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= liv_pkg::ST_IDLE;
         bad_ff   <= '0;
      end else begin
         state_ff <= state_in;
         if (req_go && cmd_in == liv_pkg::CMD_MARK_BAD && a_ok) begin
            bad_ff[req_bus.vertex_a[ROW_W-1:0]] <= 1'b1;
         end else if (req_go && cmd_in == liv_pkg::CMD_CLEAR) begin
            bad_ff <= '0;
         end
      end
   end

   always_ff @(posedge clock) begin
      case (state_ff)
         liv_pkg::ST_IDLE: begin
            if (req_go) begin
               a_ff       <= req_bus.vertex_a[ROW_W-1:0];
               b_ff       <= req_bus.vertex_b[ROW_W-1:0];
               is_forb_ff <= (cmd_in == liv_pkg::CMD_FORBID);
               idx_ff     <= '0;
            end
         end
         liv_pkg::ST_SCAN_CHK: begin
            if (eff_any) begin
               visited_ff  <= '0;
               frontier_ff <= '0;
            end else if (idx_ff == LAST_ROW) begin
               rsp_vertex_ff <= '0;
               rsp_last_ff   <= 1'b1;
               rsp_empty_ff  <= 1'b1;
            end else begin
               idx_ff <= idx_ff + ROW_W'(1);
            end
         end
         liv_pkg::ST_WALK_UPD: begin
            visited_ff    <= visited_upd;
            frontier_ff   <= frontier_upd;
            rsp_vertex_ff <= VTX_W'(idx_ff);
            rsp_last_ff   <= (frontier_upd == '0);
            rsp_empty_ff  <= 1'b0;
         end
         liv_pkg::ST_EMIT: begin
            if (rsp_go && !rsp_last_ff) begin
               idx_ff      <= pick_idx;
               frontier_ff <= frontier_pop;
            end
         end
         default: ;
      endcase
   end

   assign rsp_bus.visited_vertex = rsp_vertex_ff;
   assign rsp_bus.last           = rsp_last_ff;
   assign rsp_bus.empty_graph    = rsp_empty_ff;

endmodule
`default_nettype wire

[hdl/liv_checker.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// liv_checker
// Port-level checks on the visit order block, bound to the top level.
// ----------------------------------------------------------------------------
module liv_checker (
   input wire logic                      clock,
   input wire logic                      reset,
   input wire logic                      req_valid,
   input wire logic                      req_ready,
   input wire logic                      rsp_valid,
   input wire logic                      rsp_ready,
   input wire logic [liv_pkg::VTX_W-1:0] rsp_vertex,
   input wire logic                      rsp_last,
   input wire logic                      rsp_empty
);

   // stalled result transaction holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_vertex)
         && $stable(rsp_last) && $stable(rsp_empty))
      else $error("result changed while stalled");

   // no new command while a result is pending
   a_one_at_a_time: assert property (@(posedge clock) disable iff (reset)
      !(req_ready && rsp_valid))
      else $error("command accepted during result");

   // empty graph result is a single zero-vertex final transaction
   a_empty_form: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_empty |-> rsp_last && rsp_vertex == '0)
      else $error("malformed empty graph result");

   // walk ends and the block is ready again
   a_ready_after_last: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_ready && rsp_last |=> req_ready && !rsp_valid)
      else $error("not ready after final result");

   // walk continues busy after a non-final result
   a_busy_mid_walk: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_ready && !rsp_last |=> !req_ready && !rsp_valid)
      else $error("walk ended early");

endmodule

bind lowest_index_graph_visit_order liv_checker u_liv_checker (
   .clock      (clock),
   .reset      (reset),
   .req_valid  (req_bus.valid),
   .req_ready  (req_bus.ready),
   .rsp_valid  (rsp_bus.valid),
   .rsp_ready  (rsp_bus.ready),
   .rsp_vertex (rsp_bus.visited_vertex),
   .rsp_last   (rsp_bus.last),
   .rsp_empty  (rsp_bus.empty_graph)
);
`default_nettype wire
